/* hw/rtl/one_wire_master_with_temp_read_macros.svh */
// ----------------------------------------------------------------------------
// One-wire master assertion macros
// Shared concurrent assertion forms. Each expects clk and rst in scope and
// is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_MASTER_WITH_TEMP_READ_MACROS_SVH
`define ONE_WIRE_MASTER_WITH_TEMP_READ_MACROS_SVH

`ifndef SYNTHESIS
`define OWM_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define OWM_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define OWM_ASSERT_ALWAYS(name, cond, msg)
`define OWM_ASSERT_IMPLIES(name, ante, cons, msg)
`endif

`endif

/* hw/rtl/owm_pkg.sv */
// ----------------------------------------------------------------------------
// One-wire master package
// Operation codes, channel payload types and the queue entry shared by the
// front end, the queue and the sequencing engine.
// ----------------------------------------------------------------------------
package owm_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_RESET      = 3'd1,
    OP_WRITE_BYTE = 3'd2,
    OP_READ_BYTE  = 3'd3,
    OP_WRITE_BIT  = 3'd4,
    OP_READ_BIT   = 3'd5,
    OP_CONVERT    = 3'd6,
    OP_READ_TEMP  = 3'd7
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               rejected;
    logic               done_res;
    logic               presence;
    logic [7:0]         read_value;
    logic signed [15:0] raw_temp;
    logic signed [18:0] temp_centi;
  } out_item_t;

  // Classified item as it waits for the engine.
  typedef struct packed {
    op_t        op;
    logic       is_cmd;
    logic       load_shift;
    logic [7:0] shift_init;
    logic       clear_presence;
    logic       line_level;
  } q_entry_t;

  localparam logic [7:0] TICKS_PER_US_RESET = 8'd16;
  localparam int         QUEUE_DEPTH        = 2;

endpackage

/* hw/rtl/owm_front.sv */
// ----------------------------------------------------------------------------
// One-wire master front end
// Accepts input items and classifies them into queue entries: tick or
// command, the initial shift byte and whether a reset pulse opens the command.
// ----------------------------------------------------------------------------
module owm_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  owm_pkg::in_item_t  in_item,
  output logic               push_valid,
  input  logic               push_ready,
  output owm_pkg::q_entry_t  push_entry
);

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_entry.op             = in_item.op;
    push_entry.is_cmd         = (in_item.op != owm_pkg::OP_TICK);
    push_entry.line_level     = in_item.line_level;
    push_entry.load_shift     = 1'b0;
    push_entry.shift_init     = '0;
    push_entry.clear_presence = 1'b0;
    unique case (in_item.op) inside
      owm_pkg::OP_WRITE_BYTE: begin
        push_entry.load_shift = 1'b1;
        push_entry.shift_init = in_item.data;
      end
      owm_pkg::OP_WRITE_BIT: begin
        push_entry.load_shift = 1'b1;
        push_entry.shift_init = {7'd0, in_item.data[0]};
      end
      owm_pkg::OP_READ_BYTE, owm_pkg::OP_READ_BIT: begin
        push_entry.load_shift = 1'b1;
      end
      owm_pkg::OP_RESET, owm_pkg::OP_CONVERT, owm_pkg::OP_READ_TEMP: begin
        push_entry.clear_presence = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/owm_queue.sv */
// ----------------------------------------------------------------------------
// One-wire master item queue
// Short FIFO between the front end and the engine so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
`include "one_wire_master_with_temp_read_macros.svh"

module owm_queue #(
  parameter int DEPTH = owm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  owm_pkg::q_entry_t push_entry,
  output logic              pop_valid,
  input  logic              pop_ready,
  output owm_pkg::q_entry_t pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  owm_pkg::q_entry_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `OWM_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "queue count exceeds depth")
  `OWM_ASSERT_IMPLIES(a_empty_ptrs, count == '0, wr_ptr == rd_ptr, "empty queue with pointers apart")

endmodule

/* hw/rtl/owm_engine.sv */
// ----------------------------------------------------------------------------
// One-wire master sequencing engine
// Runs the bus sequences: prescaler, slot timer, bit and step counters, the
// shift byte and presence detection. Each queue entry yields one result in
// the result register.
// ----------------------------------------------------------------------------
`include "one_wire_master_with_temp_read_macros.svh"

module owm_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  owm_pkg::q_entry_t  pop_entry,
  output logic               res_valid,
  input  logic               res_ready,
  output owm_pkg::out_item_t res_item
);

  localparam logic [8:0] RESET_LOW_US    = 9'd480;
  localparam logic [8:0] RESET_SAMPLE_US = 9'd70;
  localparam logic [8:0] RESET_TAIL_US   = 9'd410;
  localparam logic [8:0] RESET_REL_US    = RESET_SAMPLE_US + RESET_TAIL_US;
  localparam logic [8:0] W1_LOW_US       = 9'd6;
  localparam logic [8:0] W1_REL_US       = 9'd64;
  localparam logic [8:0] W0_LOW_US       = 9'd60;
  localparam logic [8:0] W0_REL_US       = 9'd10;
  localparam logic [8:0] RD_LOW_US       = 9'd6;
  localparam logic [8:0] RD_SAMPLE_US    = 9'd9;
  localparam logic [8:0] RD_TAIL_US      = 9'd55;
  localparam logic [8:0] RD_REL_US       = RD_SAMPLE_US + RD_TAIL_US;
  localparam logic [7:0] ROM_SKIP        = 8'hCC;
  localparam logic [7:0] FN_CONVERT      = 8'h44;
  localparam logic [7:0] FN_READ_SCRATCH = 8'hBE;

  typedef enum logic [2:0] {
    K_RESET,
    K_WBYTE,
    K_RBYTE,
    K_WBIT,
    K_RBIT,
    K_NONE
  } kind_t;

  function automatic kind_t kind_of(owm_pkg::op_t cmd, logic [2:0] stp);
    kind_t k;
    k = K_NONE;
    unique case (cmd)
      owm_pkg::OP_RESET:      k = (stp == 3'd0) ? K_RESET : K_NONE;
      owm_pkg::OP_WRITE_BYTE: k = (stp == 3'd0) ? K_WBYTE : K_NONE;
      owm_pkg::OP_READ_BYTE:  k = (stp == 3'd0) ? K_RBYTE : K_NONE;
      owm_pkg::OP_WRITE_BIT:  k = (stp == 3'd0) ? K_WBIT : K_NONE;
      owm_pkg::OP_READ_BIT:   k = (stp == 3'd0) ? K_RBIT : K_NONE;
      owm_pkg::OP_CONVERT: begin
        if (stp == 3'd0) k = K_RESET;
        else if (stp <= 3'd2) k = K_WBYTE;
      end
      owm_pkg::OP_READ_TEMP: begin
        if (stp == 3'd0) k = K_RESET;
        else if (stp <= 3'd2) k = K_WBYTE;
        else if (stp <= 3'd4) k = K_RBYTE;
      end
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [8:0] low_len(kind_t k, logic b);
    logic [8:0] len;
    if (k == K_RESET) len = RESET_LOW_US;
    else if (k == K_WBYTE || k == K_WBIT) len = b ? W1_LOW_US : W0_LOW_US;
    else len = RD_LOW_US;
    return len;
  endfunction

  function automatic logic [8:0] rel_len(kind_t k, logic b);
    logic [8:0] len;
    if (k == K_RESET) len = RESET_REL_US;
    else if (k == K_WBYTE || k == K_WBIT) len = b ? W1_REL_US : W0_REL_US;
    else len = RD_REL_US;
    return len;
  endfunction

  // The command register holds OP_TICK while the bus is idle.
  owm_pkg::op_t cmd, cmd_next;
  logic       released, released_next;
  logic [8:0] slot_timer, slot_timer_next;
  logic [7:0] prescale, prescale_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_index, bit_index_next;
  logic [2:0] step, step_next;
  logic [7:0] low_byte, low_byte_next;
  logic       presence, presence_next;
  logic       drive, drive_next;
  logic [7:0] ticks_per_us;

  owm_pkg::out_item_t res_next;
  kind_t      kind;
  kind_t      next_kind;
  logic [7:0] tpu;
  logic [8:0] pre_inc;
  logic [8:0] timer_inc;
  logic [2:0] step_inc;
  logic [2:0] bit_inc;
  logic       busy;
  logic       take;
  logic       step_done;

  assign busy      = (cmd != owm_pkg::OP_TICK);
  assign pop_ready = !res_valid || res_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    kind      = kind_of(cmd, step);
    step_inc  = step + 3'd1;
    next_kind = kind_of(cmd, step_inc);
    bit_inc   = bit_index + 3'd1;
    tpu       = (ticks_per_us == '0) ? 8'd1 : ticks_per_us;
    pre_inc   = {1'b0, prescale} + 9'd1;
    timer_inc = slot_timer + 9'd1;

    cmd_next        = cmd;
    released_next   = released;
    slot_timer_next = slot_timer;
    prescale_next   = prescale;
    shift_byte_next = shift_byte;
    bit_index_next  = bit_index;
    step_next       = step;
    low_byte_next   = low_byte;
    presence_next   = presence;
    drive_next      = drive;
    step_done       = 1'b0;
    res_next        = '0;

    if (take) begin
      if (pop_entry.is_cmd) begin
        if (busy) begin
          res_next.rejected = 1'b1;
        end else begin
          cmd_next        = pop_entry.op;
          released_next   = 1'b0;
          step_next       = '0;
          bit_index_next  = '0;
          slot_timer_next = '0;
          prescale_next   = '0;
          drive_next      = 1'b1;
          if (pop_entry.load_shift) shift_byte_next = pop_entry.shift_init;
          if (pop_entry.clear_presence) presence_next = 1'b0;
        end
      end else if (busy) begin
        if (pre_inc < {1'b0, tpu}) begin
          prescale_next = pre_inc[7:0];
        end else begin
          prescale_next   = '0;
          slot_timer_next = timer_inc;
          if (!released) begin
            if (timer_inc >= low_len(kind, shift_byte[0])) begin
              drive_next      = 1'b0;
              slot_timer_next = '0;
              released_next   = 1'b1;
            end
          end else begin
            // Presence pulse and read data are sampled at fixed points after release.
            if (kind == K_RESET && timer_inc == RESET_SAMPLE_US) begin
              presence_next = ~pop_entry.line_level;
            end
            if (timer_inc == RD_SAMPLE_US) begin
              if (kind == K_RBYTE) begin
                shift_byte_next = {pop_entry.line_level, shift_byte[7:1]};
              end else if (kind == K_RBIT) begin
                shift_byte_next = {7'd0, pop_entry.line_level};
              end
            end
            if (timer_inc >= rel_len(kind, shift_byte[0])) begin
              if (kind == K_WBYTE || kind == K_RBYTE) begin
                if (kind == K_WBYTE) shift_byte_next = {1'b0, shift_byte[7:1]};
                bit_index_next = bit_inc;
                if (bit_inc == '0) begin
                  step_done = 1'b1;
                end else begin
                  drive_next      = 1'b1;
                  slot_timer_next = '0;
                  released_next   = 1'b0;
                end
              end else begin
                step_done = 1'b1;
              end
            end
            if (step_done) begin
              if (cmd == owm_pkg::OP_READ_TEMP && step == 3'd3) begin
                low_byte_next = shift_byte_next;
              end
              if (next_kind == K_NONE) begin
                res_next.done_res = 1'b1;
                if (cmd == owm_pkg::OP_READ_BYTE || cmd == owm_pkg::OP_READ_BIT) begin
                  res_next.read_value = shift_byte_next;
                end
                if (cmd == owm_pkg::OP_READ_TEMP) begin
                  res_next.raw_temp = {shift_byte_next, low_byte_next};
                end
                cmd_next        = owm_pkg::OP_TICK;
                released_next   = 1'b0;
                step_next       = '0;
                slot_timer_next = '0;
                drive_next      = 1'b0;
              end else begin
                step_next       = step_inc;
                bit_index_next  = '0;
                drive_next      = 1'b1;
                slot_timer_next = '0;
                released_next   = 1'b0;
                if (next_kind == K_WBYTE) begin
                  if (step_inc == 3'd2) begin
                    shift_byte_next = (cmd == owm_pkg::OP_CONVERT) ? FN_CONVERT
                                                                    : FN_READ_SCRATCH;
                  end else begin
                    shift_byte_next = ROM_SKIP;
                  end
                end else if (next_kind == K_RBYTE || next_kind == K_RBIT) begin
                  shift_byte_next = '0;
                end
              end
            end
          end
        end
      end
    end

    res_next.drive_low = drive_next;
    res_next.busy_res  = (cmd_next != owm_pkg::OP_TICK);
    res_next.presence  = presence_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd          <= owm_pkg::OP_TICK;
      released     <= 1'b0;
      slot_timer   <= '0;
      prescale     <= '0;
      shift_byte   <= '0;
      bit_index    <= '0;
      step         <= '0;
      low_byte     <= '0;
      presence     <= 1'b0;
      drive        <= 1'b0;
      ticks_per_us <= owm_pkg::TICKS_PER_US_RESET;
      res_valid    <= 1'b0;
    end else begin
      cmd        <= cmd_next;
      released   <= released_next;
      slot_timer <= slot_timer_next;
      prescale   <= prescale_next;
      shift_byte <= shift_byte_next;
      bit_index  <= bit_index_next;
      step       <= step_next;
      low_byte   <= low_byte_next;
      presence   <= presence_next;
      drive      <= drive_next;
      if (cfg_we) ticks_per_us <= cfg_data;
      if (pop_ready) res_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_item <= res_next;
    end
  end

  `OWM_ASSERT_IMPLIES(a_idle_released, !busy, !drive, "bus driven low while idle")
  `OWM_ASSERT_IMPLIES(a_reject_busy, res_valid && res_item.rejected, res_item.busy_res, "rejected command reported while idle")
  `OWM_ASSERT_IMPLIES(a_done_idle, res_valid && res_item.done_res, !res_item.busy_res && !res_item.drive_low, "finished command left the bus active")

endmodule

/* hw/rtl/owm_result.sv */
// ----------------------------------------------------------------------------
// One-wire master result stage
// Scales the raw temperature to hundredths of a degree and holds the result
// for the output channel.
// ----------------------------------------------------------------------------
`include "one_wire_master_with_temp_read_macros.svh"

module owm_result (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_ready,
  input  owm_pkg::out_item_t res_item,
  output logic               out_valid,
  input  logic               out_ready,
  output owm_pkg::out_item_t out_item
);

  logic signed [20:0] raw_ext;
  logic signed [20:0] times25;
  logic signed [20:0] biased;
  logic signed [18:0] centi;
  owm_pkg::out_item_t scaled;

  // raw * 625 / 100 equals raw * 25 / 4; the bias makes the shift round toward zero.
  always_comb begin
    raw_ext = 21'(res_item.raw_temp);
    times25 = (raw_ext <<< 4) + (raw_ext <<< 3) + raw_ext;
    biased  = times25 + (times25[20] ? 21'sd3 : 21'sd0);
    centi   = 19'(biased >>> 2);
    scaled            = res_item;
    scaled.temp_centi = centi;
  end

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= scaled;
    end
  end

  `OWM_ASSERT_IMPLIES(a_centi_sign, out_valid && out_item.raw_temp[15], out_item.temp_centi[18], "scaled temperature lost its sign")

endmodule

/* hw/rtl/one_wire_master_with_temp_read.sv */
// ----------------------------------------------------------------------------
// One-wire bus master with temperature read
// Bus master that times reset, write and read slots from tick items and runs
// the skip-ROM convert and scratchpad read sequences.
// ----------------------------------------------------------------------------
// Every input item, tick or command, yields exactly one result transfer, and
// the block sustains one item per clock while the output is not stalled: the
// engine updates its prescaler, slot timer and shift state once per item it
// takes. An item is written into a queue slot at its input transfer, then
// passes to the engine result register and on to the scaling register, which
// holds the output result. The item queue decouples input from the engine,
// so while a result waits on the output the input still takes up to
// QUEUE_DEPTH + 1 further transfers: one into the engine result register and
// QUEUE_DEPTH into the queue. The configuration port is always ready;
// ticks_per_us should only be written while no command is running.
module one_wire_master_with_temp_read #(
  parameter int QUEUE_DEPTH = owm_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  owm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output owm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic               push_valid;
  logic               push_ready;
  owm_pkg::q_entry_t  push_entry;
  logic               pop_valid;
  logic               pop_ready;
  owm_pkg::q_entry_t  pop_entry;
  logic               res_valid;
  logic               res_ready;
  owm_pkg::out_item_t res_item;

  assign cfg_ready = 1'b1;

  owm_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  owm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  owm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  owm_result u_result (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* test/one_wire_master_with_temp_read_tb.sv */
// ----------------------------------------------------------------------------
// One-wire master testbench
// Feeds tick and command items through the input channel, with bus levels
// laid out so that presence and read samples land on known values, and
// checks every result transfer against a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_wire_master_with_temp_read_tb;

  localparam int RESET_LOW_US    = 480;
  localparam int RESET_SAMPLE_US = 70;
  localparam int RESET_TAIL_US   = 410;
  localparam int W1_LOW_US       = 6;
  localparam int W1_REL_US       = 64;
  localparam int W0_LOW_US       = 60;
  localparam int W0_REL_US       = 10;
  localparam int RD_LOW_US       = 6;
  localparam int RD_SAMPLE_US    = 9;
  localparam int RD_TAIL_US      = 55;
  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT_T    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;
  localparam int CENTI_MUL = 625;
  localparam int CENTI_DIV = 100;

  // Every bit slot lasts the same time whatever its kind.
  localparam int BIT_SLOT_US       = W1_LOW_US + W1_REL_US;
  localparam int READ_POINT_US     = RD_LOW_US + RD_SAMPLE_US;
  localparam int RESET_SPAN_US     = RESET_LOW_US + RESET_SAMPLE_US + RESET_TAIL_US;
  localparam int PRESENCE_POINT_US = RESET_LOW_US + RESET_SAMPLE_US;
  localparam longint CYCLE_LIMIT   = 500_000;

  typedef enum {SK_RESET, SK_WBYTE, SK_RBYTE, SK_WBIT, SK_RBIT, SK_NONE} slot_kind_t;

  typedef struct packed {
    owm_pkg::in_item_t item;
    logic              drain_first;
  } feed_entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  owm_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  owm_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = 8'd0;

  feed_entry_t        feed_q[$];
  owm_pkg::out_item_t result_q[$];
  int                 errors = 0;
  longint             cycle_count = 0;
  int                 send_gap = 0;
  int                 recv_gap = 0;
  int                 noise_pct = 0;
  bit                 drain_next = 1'b0;
  int                 fed_items = 0;
  logic [7:0]         gen_tpu = owm_pkg::TICKS_PER_US_RESET;

  // Sequencer model state. run_cmd holds OP_TICK while no command runs.
  owm_pkg::op_t run_cmd;
  logic         rel_phase;
  logic [8:0]   slot_us;
  logic [7:0]   pre_cnt;
  logic [7:0]   shreg;
  logic [2:0]   bit_no;
  logic [2:0]   step_no;
  logic [7:0]   lsb_store;
  logic         pres;
  logic         drv;
  logic [7:0]   tpu;

  one_wire_master_with_temp_read u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void reset_model();
    run_cmd = owm_pkg::OP_TICK;
    rel_phase = 1'b0;
    slot_us = '0;
    pre_cnt = '0;
    shreg = '0;
    bit_no = '0;
    step_no = '0;
    lsb_store = '0;
    pres = 1'b0;
    drv = 1'b0;
    tpu = owm_pkg::TICKS_PER_US_RESET;
  endfunction

  function automatic slot_kind_t kind_at(owm_pkg::op_t c, logic [2:0] s);
    case (c)
      owm_pkg::OP_RESET:      return (s == 0) ? SK_RESET : SK_NONE;
      owm_pkg::OP_WRITE_BYTE: return (s == 0) ? SK_WBYTE : SK_NONE;
      owm_pkg::OP_READ_BYTE:  return (s == 0) ? SK_RBYTE : SK_NONE;
      owm_pkg::OP_WRITE_BIT:  return (s == 0) ? SK_WBIT : SK_NONE;
      owm_pkg::OP_READ_BIT:   return (s == 0) ? SK_RBIT : SK_NONE;
      owm_pkg::OP_CONVERT:    return (s == 0) ? SK_RESET : (s <= 2) ? SK_WBYTE : SK_NONE;
      owm_pkg::OP_READ_TEMP:  return (s == 0) ? SK_RESET : (s <= 2) ? SK_WBYTE :
                                     (s <= 4) ? SK_RBYTE : SK_NONE;
      default:                return SK_NONE;
    endcase
  endfunction

  function automatic int low_us(slot_kind_t k, logic b);
    case (k)
      SK_RESET:          return RESET_LOW_US;
      SK_WBYTE, SK_WBIT: return b ? W1_LOW_US : W0_LOW_US;
      default:           return RD_LOW_US;
    endcase
  endfunction

  function automatic int rel_us(slot_kind_t k, logic b);
    case (k)
      SK_RESET:          return RESET_SAMPLE_US + RESET_TAIL_US;
      SK_WBYTE, SK_WBIT: return b ? W1_REL_US : W0_REL_US;
      default:           return RD_SAMPLE_US + RD_TAIL_US;
    endcase
  endfunction

  function automatic void begin_slot(owm_pkg::op_t c, slot_kind_t k);
    if (k == SK_RESET) pres = 1'b0;
    drv = 1'b1;
    slot_us = '0;
    pre_cnt = '0;
    run_cmd = c;
    rel_phase = 1'b0;
  endfunction

  function automatic void begin_step(owm_pkg::op_t c, logic [2:0] s);
    slot_kind_t k;
    k = kind_at(c, s);
    if (k == SK_WBYTE && c != owm_pkg::OP_WRITE_BYTE) begin
      if (c == owm_pkg::OP_CONVERT && s == 2) shreg = CMD_CONVERT_T;
      else if (c == owm_pkg::OP_READ_TEMP && s == 2) shreg = CMD_READ_SCRATCH;
      else shreg = CMD_SKIP_ROM;
    end
    if (k == SK_RBYTE || k == SK_RBIT) shreg = '0;
    bit_no = '0;
    begin_slot(c, k);
  endfunction

  function automatic owm_pkg::out_item_t bus_step(owm_pkg::in_item_t it);
    owm_pkg::out_item_t r;
    int                 lim;
    slot_kind_t         k;
    logic               b;
    logic               fin;
    int                 raw_v;
    int                 centi_v;
    r = '0;
    if (it.op != owm_pkg::OP_TICK) begin
      if (run_cmd != owm_pkg::OP_TICK) begin
        r.rejected = 1'b1;
      end else begin
        step_no = '0;
        case (it.op)
          owm_pkg::OP_WRITE_BYTE: begin
            shreg = it.data;
            bit_no = '0;
            begin_slot(it.op, kind_at(it.op, 3'd0));
          end
          owm_pkg::OP_WRITE_BIT: begin
            shreg = {7'd0, it.data[0]};
            bit_no = '0;
            begin_slot(it.op, kind_at(it.op, 3'd0));
          end
          default: begin_step(it.op, 3'd0);
        endcase
      end
    end else if (run_cmd != owm_pkg::OP_TICK) begin
      lim = (tpu == 0) ? 1 : int'(tpu);
      if (int'(pre_cnt) + 1 < lim) begin
        pre_cnt = pre_cnt + 8'd1;
      end else begin
        k = kind_at(run_cmd, step_no);
        b = shreg[0];
        fin = 1'b0;
        pre_cnt = '0;
        slot_us = slot_us + 9'd1;
        if (!rel_phase) begin
          if (slot_us >= low_us(k, b)) begin
            drv = 1'b0;
            slot_us = '0;
            rel_phase = 1'b1;
          end
        end else begin
          // A low line at the sample point means a device is present.
          if (k == SK_RESET && slot_us == RESET_SAMPLE_US) pres = ~it.line_level;
          if ((k == SK_RBYTE || k == SK_RBIT) && slot_us == RD_SAMPLE_US) begin
            if (k == SK_RBYTE) shreg = {it.line_level, shreg[7:1]};
            else shreg = {7'd0, it.line_level};
          end
          if (slot_us >= rel_us(k, b)) begin
            if (k == SK_WBYTE || k == SK_RBYTE) begin
              if (k == SK_WBYTE) shreg = shreg >> 1;
              bit_no = bit_no + 3'd1;
              if (bit_no == 3'd0) fin = 1'b1;
              else begin_slot(run_cmd, k);
            end else begin
              fin = 1'b1;
            end
          end
          if (fin) begin
            if (run_cmd == owm_pkg::OP_READ_TEMP && step_no == 3) lsb_store = shreg;
            step_no = step_no + 3'd1;
            if (kind_at(run_cmd, step_no) == SK_NONE) begin
              r.done_res = 1'b1;
              if (run_cmd == owm_pkg::OP_READ_BYTE || run_cmd == owm_pkg::OP_READ_BIT)
                r.read_value = shreg;
              if (run_cmd == owm_pkg::OP_READ_TEMP) begin
                r.raw_temp = {shreg, lsb_store};
                raw_v = int'(r.raw_temp);
                centi_v = (raw_v * CENTI_MUL) / CENTI_DIV;
                r.temp_centi = centi_v[18:0];
              end
              run_cmd = owm_pkg::OP_TICK;
              step_no = '0;
              slot_us = '0;
              drv = 1'b0;
            end else begin
              begin_step(run_cmd, step_no);
            end
          end
        end
      end
    end
    r.drive_low = drv;
    r.busy_res = (run_cmd != owm_pkg::OP_TICK);
    r.presence = pres;
    return r;
  endfunction

  // --------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      reset_model();
    end else begin
      if (in_valid && in_ready) result_q.push_back(bus_step(in_item));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0 &&
                     !(feed_q[0].drain_first && result_q.size() > 0)) begin
          in_item <= feed_q[0].item;
          feed_q.pop_front();
          in_valid <= 1'b1;
          send_gap = $urandom_range(0, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- monitor

  task automatic flag_error(string what, logic [18:0] want_v, logic [18:0] got_v);
    errors++;
    if (errors <= 10)
      $display("MISMATCH at %0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  task automatic check_field(string what, logic [18:0] want_v, logic [18:0] got_v);
    if (got_v !== want_v) flag_error(what, want_v, got_v);
  endtask

  task automatic compare_result(owm_pkg::out_item_t want, owm_pkg::out_item_t got);
    check_field("drive_low", 19'(want.drive_low), 19'(got.drive_low));
    check_field("busy_res", 19'(want.busy_res), 19'(got.busy_res));
    check_field("rejected", 19'(want.rejected), 19'(got.rejected));
    check_field("done_res", 19'(want.done_res), 19'(got.done_res));
    check_field("presence", 19'(want.presence), 19'(got.presence));
    check_field("read_value", 19'(want.read_value), 19'(got.read_value));
    check_field("raw_temp", 19'(want.raw_temp), 19'(got.raw_temp));
    check_field("temp_centi", want.temp_centi, got.temp_centi);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) flag_error("unexpected result, read_value", '0,
                                             19'(out_item.read_value));
        else compare_result(result_q.pop_front(), out_item);
        recv_gap = $urandom_range(0, 18);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic put(owm_pkg::op_t op, logic [7:0] d, logic line);
    feed_entry_t e;
    e.item.op = op;
    e.item.data = d;
    e.item.line_level = line;
    e.drain_first = drain_next;
    drain_next = 1'b0;
    feed_q.push_back(e);
    fed_items++;
  endtask

  function automatic int us_ticks();
    return (gen_tpu == 0) ? 1 : int'(gen_tpu);
  endfunction

  // One slot of ticks with a noisy line, except at the tick where the block
  // samples, which carries the requested level.
  task automatic emit_slot(int span_us, int sample_us, logic sample_val);
    int n;
    int at;
    n = span_us * us_ticks();
    at = (sample_us > 0) ? sample_us * us_ticks() - 1 : -1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        put(owm_pkg::op_t'($urandom_range(1, 7)), rand_byte(), rand_bit());
      put(owm_pkg::OP_TICK, rand_byte(), (i == at) ? sample_val : rand_bit());
    end
  endtask

  task automatic emit_cmd(owm_pkg::op_t c, logic [7:0] d, logic present, logic [15:0] rd);
    put(c, d, rand_bit());
    case (c)
      owm_pkg::OP_RESET:      emit_slot(RESET_SPAN_US, PRESENCE_POINT_US, !present);
      owm_pkg::OP_WRITE_BIT:  emit_slot(BIT_SLOT_US, 0, 1'b0);
      owm_pkg::OP_READ_BIT:   emit_slot(BIT_SLOT_US, READ_POINT_US, rd[0]);
      owm_pkg::OP_WRITE_BYTE: repeat (8) emit_slot(BIT_SLOT_US, 0, 1'b0);
      owm_pkg::OP_READ_BYTE:
        for (int i = 0; i < 8; i++) emit_slot(BIT_SLOT_US, READ_POINT_US, rd[i]);
      owm_pkg::OP_CONVERT, owm_pkg::OP_READ_TEMP: begin
        emit_slot(RESET_SPAN_US, PRESENCE_POINT_US, !present);
        repeat (16) emit_slot(BIT_SLOT_US, 0, 1'b0);
        if (c == owm_pkg::OP_READ_TEMP)
          for (int i = 0; i < 16; i++) emit_slot(BIT_SLOT_US, READ_POINT_US, rd[i]);
      end
      default: ;
    endcase
  endtask

  // Waits until every queued item has been sent and answered. The check runs
  // on the falling edge so that the driver's and monitor's updates have landed.
  task automatic drain();
    while (feed_q.size() > 0 || in_valid || result_q.size() > 0) @(negedge clk);
  endtask

  // Drains, then keeps ticking until no command is left running.
  task automatic settle();
    do begin
      drain();
      if (run_cmd != owm_pkg::OP_TICK)
        repeat (64) put(owm_pkg::OP_TICK, rand_byte(), rand_bit());
    end while (run_cmd != owm_pkg::OP_TICK);
  endtask

  task automatic program_tpu(logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tpu = v;
    gen_tpu = v;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset-value rate: ticks while idle, then the low part of a write-one
    // slot at sixteen ticks per microsecond.
    put(owm_pkg::OP_TICK, 8'h00, 1'b0);
    put(owm_pkg::OP_TICK, 8'hFF, 1'b1);
    put(owm_pkg::OP_WRITE_BIT, 8'h01, 1'b0);
    repeat (100) put(owm_pkg::OP_TICK, rand_byte(), rand_bit());
    drain();
    // The rest of the slot runs at one tick per microsecond.
    program_tpu(8'd1);
    settle();

    noise_pct = 2;
    emit_cmd(owm_pkg::OP_READ_BIT, 8'hFF, 1'b0, 16'h0001);
    emit_cmd(owm_pkg::OP_WRITE_BIT, 8'hFE, 1'b0, 16'h0000);
    drain_next = 1'b1;
    emit_cmd(owm_pkg::OP_READ_BYTE, 8'h00, 1'b0, 16'h005A);
    settle();

    // A zero rate behaves as one tick per microsecond.
    program_tpu(8'd0);
    emit_cmd(owm_pkg::OP_READ_BIT, 8'h00, 1'b0, 16'h0000);
    settle();

    // A write byte that is still running when the stimulus ends.
    put(owm_pkg::OP_WRITE_BYTE, 8'hA5, 1'b1);
    repeat (200) put(owm_pkg::OP_TICK, rand_byte(), rand_bit());
    drain();

    repeat (20) @(posedge clk);
    if (result_q.size() != 0) errors++;
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/owm_pkg.sv
hw/rtl/owm_front.sv
hw/rtl/owm_queue.sv
hw/rtl/owm_engine.sv
hw/rtl/owm_result.sv
hw/rtl/one_wire_master_with_temp_read.sv
test/one_wire_master_with_temp_read_tb.sv
